// ----- src/sli_pkg.sv -----
// Shared types and constants for the segmented learned index lookup unit.
package sli_pkg;

    localparam int KEY_W        = 64;
    localparam int RATIO_W      = 17;
    localparam int EPOCH_W      = 16;
    localparam int CNT_W        = 11;
    localparam int DIV_MW       = 25;

    localparam int RATIO_FLOOR  = 3277;
    localparam int RATIO_ONE    = 65536;
    localparam int EPOCH_CAP    = 8;
    localparam int SPAN_NUM     = 16777216;

    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_SEARCH_WINDOW = 16;
    localparam int DEF_MIN_SPAN      = 32;
    localparam int DEF_MAX_SPAN      = 4096;

    localparam logic CFG_RATIO = 1'b0;
    localparam logic CFG_EPOCH = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_BUILD  = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTBUILT = 2'd2
    } t_status;

endpackage

// ----- src/segmented_learned_index_lookup_unit.sv -----
// Top level of the segmented learned index lookup unit.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------------
//  command   | start / busy               | i_operation, i_key, i_value
//  result    | o_valid (one-cycle strobe) | o_status, o_hit, o_found_value, totals
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A command transfers when start is high and busy is low; busy stays high until
// the result strobe. Clear resets the counts. Insert runs a binary search, then
// moves the entries above the slot up one at a time. Build runs the span
// divisions in the serial divider, then writes the first key of each segment.
// Lookup searches the segment starts, predicts a position with the serial divider
// and searches the window around it; the divider works through its 25 multiplier
// bits one by one, with an added step for each set bit. Config transfers only while idle.
// Reset is synchronous and active low; the stores need no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
module segmented_learned_index_lookup_unit #(
    parameter int TABLE_DEPTH   = sli_pkg::DEF_TABLE_DEPTH,
    parameter int SEARCH_WINDOW = sli_pkg::DEF_SEARCH_WINDOW,
    parameter int MIN_SPAN      = sli_pkg::DEF_MIN_SPAN,
    parameter int MAX_SPAN      = sli_pkg::DEF_MAX_SPAN
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_operation,
    input  logic [63:0]                 i_key,
    input  logic [63:0]                 i_value,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic                        o_hit,
    output logic [63:0]                 o_found_value,
    output logic [sli_pkg::CNT_W-1:0]   o_entry_total,
    output logic [sli_pkg::CNT_W-1:0]   o_segment_total,
    output logic [63:0]                 o_query_total,
    output logic [63:0]                 o_miss_total,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [sli_pkg::RATIO_W-1:0] i_cfg_data
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int SW   = $clog2(MAX_SPAN + 1);
    localparam int PW   = CW + SW;
    localparam int MW   = sli_pkg::DIV_MW;
    localparam int CNTW = sli_pkg::CNT_W;
    localparam int RW   = sli_pkg::RATIO_W;
    localparam int EW   = sli_pkg::EPOCH_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SRD, S_SCMP, S_PRD, S_PCHK, S_MVRD, S_MVWR, S_INSW,
        S_SPAN1, S_SPAN2, S_SPCL, S_BRD, S_BWR,
        S_LBEG, S_LEND, S_LFL, S_LDIV, S_LWIN, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        P_INS, P_SEG, P_WIN, P_FULL
    } t_pass;

    t_state          r_state, n_state;
    t_pass           r_pass, n_pass;
    sli_pkg::t_op    r_op, n_op;
    logic [63:0]     r_key, n_key, r_val, n_val;
    logic [RW-1:0]   r_ratio, n_ratio;
    logic [EW-1:0]   r_epoch, n_epoch;
    logic [CW-1:0]   r_count, n_count, r_segcnt, n_segcnt;
    logic [SW-1:0]   r_span, n_span;
    logic            r_ready, n_ready;
    logic [63:0]     r_query, n_query, r_miss, n_miss;
    logic [CW-1:0]   r_lo, n_lo, r_hi, n_hi, r_bound, n_bound, r_pos, n_pos, r_i, n_i;
    logic [PW-1:0]   r_begin, n_begin, r_end, n_end, r_approx, n_approx, r_b, n_b;
    logic [63:0]     r_first, n_first;
    logic [MW-1:0]   r_w, n_w;
    logic [MW-1:0]   r_dm, n_dm;
    logic [63:0]     r_dd, n_dd, r_dr, n_dr;
    logic            r_dgo, n_dgo;
    sli_pkg::t_status r_status, n_status;
    logic            r_hit, n_hit;
    logic [63:0]     r_found, n_found;

    logic            r_o_valid, n_o_valid;
    logic [1:0]      r_o_status, n_o_status;
    logic            r_o_hit, n_o_hit;
    logic [63:0]     r_o_found, n_o_found;
    logic [CNTW-1:0] r_o_entry, n_o_entry, r_o_seg, n_o_seg;
    logic [63:0]     r_o_query, n_o_query, r_o_miss, n_o_miss;

    // memories
    logic            k_we, v_we, s_we;
    logic [AW-1:0]   k_waddr, s_waddr, k_raddr, s_raddr;
    logic [63:0]     k_wdata, v_wdata, s_wdata, k_rdata, v_rdata, s_rdata;

    logic            div_done;
    logic [MW-1:0]   div_quot;

    logic [CW-1:0]   mid, idx;
    logic            go_right, match;
    logic [RW-1:0]   ratio_c;
    logic [3:0]      epoch_c;
    logic [31:0]     w32;
    logic [PW-1:0]   end_sum, end_c, win_a, win_lo, win_hi, nb;

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign go_right = (r_pass == P_SEG) ? (s_rdata <= r_key) : (k_rdata < r_key);
    assign match    = (r_pos < r_bound) && (k_rdata == r_key);
    assign idx      = (r_lo == '0) ? '0 : r_lo - 1'b1;
    assign end_sum  = r_begin + PW'(r_span);
    assign end_c    = (end_sum > PW'(r_count)) ? PW'(r_count) : end_sum;
    assign nb       = r_b + PW'(r_span);

    // clamp the ratio and epoch settings
    always_comb begin
        ratio_c = r_ratio;
        if (r_ratio < RW'(sli_pkg::RATIO_FLOOR)) ratio_c = RW'(sli_pkg::RATIO_FLOOR);
        if (r_ratio > RW'(sli_pkg::RATIO_ONE))   ratio_c = RW'(sli_pkg::RATIO_ONE);
        epoch_c = 4'(r_epoch);
        if (r_epoch == '0) epoch_c = 4'd1;
        if (r_epoch > EW'(sli_pkg::EPOCH_CAP)) epoch_c = 4'(sli_pkg::EPOCH_CAP);
    end

    // clamp the raw span to the configured bounds and entry count
    always_comb begin
        w32 = 32'(r_w);
        if (w32 < 32'(MIN_SPAN)) w32 = 32'(MIN_SPAN);
        if (w32 > 32'(MAX_SPAN)) w32 = 32'(MAX_SPAN);
        if (w32 > 32'(r_count))  w32 = 32'(r_count);
        if (w32 == 32'd0)        w32 = 32'd1;
    end

    // search window around the prediction, kept inside the segment
    always_comb begin
        win_a = (r_approx > r_end - 1'b1) ? r_end - 1'b1 : r_approx;
        win_lo = (win_a > PW'(SEARCH_WINDOW)) ? win_a - PW'(SEARCH_WINDOW) : '0;
        if (win_lo < r_begin) win_lo = r_begin;
        win_hi = win_a + PW'(SEARCH_WINDOW) + 1'b1;
        if (win_hi > r_end) win_hi = r_end;
    end

    always_comb begin
        n_state  = r_state;   n_pass   = r_pass;   n_op     = r_op;
        n_key    = r_key;     n_val    = r_val;    n_ratio  = r_ratio;
        n_epoch  = r_epoch;   n_count  = r_count;  n_segcnt = r_segcnt;
        n_span   = r_span;    n_ready  = r_ready;  n_query  = r_query;
        n_miss   = r_miss;    n_lo     = r_lo;     n_hi     = r_hi;
        n_bound  = r_bound;   n_pos    = r_pos;    n_i      = r_i;
        n_begin  = r_begin;   n_end    = r_end;    n_approx = r_approx;
        n_b      = r_b;       n_first  = r_first;
        n_w      = r_w;       n_dm     = r_dm;     n_dd     = r_dd;
        n_dr     = r_dr;      n_dgo    = 1'b0;     n_status = r_status;
        n_hit    = r_hit;     n_found  = r_found;
        n_o_valid = 1'b0;     n_o_status = r_o_status; n_o_hit = r_o_hit;
        n_o_found = r_o_found; n_o_entry = r_o_entry; n_o_seg = r_o_seg;
        n_o_query = r_o_query; n_o_miss = r_o_miss;
        k_we = 1'b0; v_we = 1'b0; s_we = 1'b0;
        k_waddr = r_pos[AW-1:0]; k_wdata = r_key; v_wdata = r_val;
        s_waddr = r_segcnt[AW-1:0]; s_wdata = k_rdata;
        k_raddr = r_pos[AW-1:0]; s_raddr = mid[AW-1:0];

        // configuration writes land only while idle
        if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == sli_pkg::CFG_RATIO) begin
                n_ratio = i_cfg_data;
            end else begin
                n_epoch = i_cfg_data[EW-1:0];
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = sli_pkg::t_op'(i_operation);
                    n_key    = i_key;
                    n_val    = i_value;
                    n_status = sli_pkg::STAT_OK;
                    n_hit    = 1'b0;
                    n_found  = '0;
                    unique case (sli_pkg::t_op'(i_operation))
                        sli_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_segcnt = '0;
                            n_ready  = 1'b0;
                            n_state  = S_DONE;
                        end
                        sli_pkg::OP_INSERT: begin
                            n_ready = 1'b0;
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_bound = r_count;
                            n_pass  = P_INS;
                            n_state = S_SRD;
                        end
                        sli_pkg::OP_BUILD: begin
                            n_segcnt = '0;
                            n_ready  = 1'b0;
                            if (r_count == '0) begin
                                n_span  = SW'(1);
                                n_state = S_DONE;
                            end else begin
                                // round(2^24 / ratio)
                                n_dm    = MW'(sli_pkg::SPAN_NUM) + MW'(ratio_c >> 1);
                                n_dd    = 64'd1;
                                n_dr    = 64'(ratio_c);
                                n_dgo   = 1'b1;
                                n_state = S_SPAN1;
                            end
                        end
                        sli_pkg::OP_LOOKUP: begin
                            n_query = r_query + 1'b1;
                            if (!r_ready) begin
                                n_status = sli_pkg::STAT_NOTBUILT;
                                n_state  = S_DONE;
                            end else begin
                                n_lo    = '0;
                                n_hi    = r_segcnt;
                                n_pass  = P_SEG;
                                n_state = S_SRD;
                            end
                        end
                    endcase
                end
            end

            // binary search: issue a read at mid, or finish
            S_SRD: begin
                s_raddr = mid[AW-1:0];
                k_raddr = mid[AW-1:0];
                if (r_lo < r_hi) begin
                    n_state = S_SCMP;
                end else if (r_pass == P_SEG) begin
                    n_state = S_LBEG;
                end else begin
                    n_pos   = r_lo;
                    n_state = S_PRD;
                end
            end

            S_SCMP: begin
                if (go_right) begin
                    n_lo = mid + 1'b1;
                end else begin
                    n_hi = mid;
                end
                n_state = S_SRD;
            end

            S_PRD: begin
                k_raddr = r_pos[AW-1:0];
                n_state = S_PCHK;
            end

            S_PCHK: begin
                priority case (r_pass)
                    P_INS: begin
                        if (match) begin
                            // equal key keeps the larger value
                            if (r_val > v_rdata) begin
                                v_we = 1'b1;
                            end
                            n_state = S_DONE;
                        end else if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_status = sli_pkg::STAT_FULL;
                            n_state  = S_DONE;
                        end else if (r_count == r_pos) begin
                            n_state = S_INSW;
                        end else begin
                            n_i     = r_count;
                            n_state = S_MVRD;
                        end
                    end
                    P_WIN: begin
                        if (match) begin
                            n_hit   = 1'b1;
                            n_found = v_rdata;
                            n_state = S_DONE;
                        end else begin
                            // fall back to the whole segment
                            n_lo    = CW'(r_begin);
                            n_hi    = CW'(r_end);
                            n_bound = CW'(r_end);
                            n_pass  = P_FULL;
                            n_state = S_SRD;
                        end
                    end
                    default: begin
                        if (match) begin
                            n_hit   = 1'b1;
                            n_found = v_rdata;
                        end
                        n_state = S_DONE;
                    end
                endcase
            end

            // shift entries up by one, top down
            S_MVRD: begin
                k_raddr = AW'(r_i - 1'b1);
                n_state = S_MVWR;
            end

            S_MVWR: begin
                k_we    = 1'b1;
                v_we    = 1'b1;
                k_waddr = r_i[AW-1:0];
                k_wdata = k_rdata;
                v_wdata = v_rdata;
                n_i     = r_i - 1'b1;
                n_state = (r_i - 1'b1 == r_pos) ? S_INSW : S_MVRD;
            end

            S_INSW: begin
                k_we    = 1'b1;
                v_we    = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end

            S_SPAN1: begin
                if (div_done) begin
                    if (epoch_c == 4'd1) begin
                        n_w     = div_quot;
                        n_state = S_SPCL;
                    end else begin
                        n_dm    = div_quot;
                        n_dd    = 64'd1;
                        n_dr    = 64'(epoch_c);
                        n_dgo   = 1'b1;
                        n_state = S_SPAN2;
                    end
                end
            end

            S_SPAN2: begin
                if (div_done) begin
                    n_w     = div_quot;
                    n_state = S_SPCL;
                end
            end

            S_SPCL: begin
                n_span  = w32[SW-1:0];
                n_b     = '0;
                n_state = S_BRD;
            end

            // record the first key of each segment
            S_BRD: begin
                k_raddr = r_b[AW-1:0];
                n_state = S_BWR;
            end

            S_BWR: begin
                s_we     = 1'b1;
                n_segcnt = r_segcnt + 1'b1;
                n_b      = nb;
                if (nb >= PW'(r_count)) begin
                    n_ready = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_BRD;
                end
            end

            S_LBEG: begin
                s_raddr = idx[AW-1:0];
                n_pos   = idx;
                n_begin = PW'(idx) * PW'(r_span);
                n_state = S_LEND;
            end

            S_LEND: begin
                k_raddr = AW'(end_c - 1'b1);
                n_first = s_rdata;
                n_end   = end_c;
                n_state = (r_begin >= end_c) ? S_DONE : S_LFL;
            end

            S_LFL: begin
                n_approx = r_begin;
                n_state  = S_LWIN;
                if (r_key > r_first && k_rdata > r_first && r_end > r_begin + 1'b1) begin
                    if (r_key - r_first >= k_rdata - r_first) begin
                        n_approx = r_end - 1'b1;
                    end else begin
                        n_dm    = MW'(r_end - r_begin - 1'b1);
                        n_dd    = r_key - r_first;
                        n_dr    = k_rdata - r_first;
                        n_dgo   = 1'b1;
                        n_state = S_LDIV;
                    end
                end
            end

            S_LDIV: begin
                if (div_done) begin
                    n_approx = r_begin + PW'(div_quot);
                    n_state  = S_LWIN;
                end
            end

            S_LWIN: begin
                n_lo    = CW'(win_lo);
                n_hi    = CW'(win_hi);
                n_bound = CW'(win_hi);
                n_pass  = P_WIN;
                n_state = S_SRD;
            end

            S_DONE: begin
                n_o_valid  = 1'b1;
                n_o_status = r_status;
                n_o_hit    = r_hit;
                n_o_found  = r_hit ? r_found : '0;
                n_o_entry  = CNTW'(r_count);
                n_o_seg    = CNTW'(r_segcnt);
                n_o_query  = r_query;
                if (r_op == sli_pkg::OP_LOOKUP && !r_hit) begin
                    n_miss   = r_miss + 1'b1;
                    n_o_miss = r_miss + 1'b1;
                end else begin
                    n_o_miss = r_miss;
                end
                n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ratio   <= RW'(sli_pkg::RATIO_ONE);
            r_epoch   <= EW'(1);
            r_count   <= '0;
            r_segcnt  <= '0;
            r_span    <= SW'(1);
            r_ready   <= 1'b0;
            r_query   <= '0;
            r_miss    <= '0;
            r_dgo     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ratio   <= n_ratio;
            r_epoch   <= n_epoch;
            r_count   <= n_count;
            r_segcnt  <= n_segcnt;
            r_span    <= n_span;
            r_ready   <= n_ready;
            r_query   <= n_query;
            r_miss    <= n_miss;
            r_dgo     <= n_dgo;
            r_o_valid <= n_o_valid;
        end
        r_pass   <= n_pass;   r_op     <= n_op;     r_key    <= n_key;
        r_val    <= n_val;    r_lo     <= n_lo;     r_hi     <= n_hi;
        r_bound  <= n_bound;  r_pos    <= n_pos;    r_i      <= n_i;
        r_begin  <= n_begin;  r_end    <= n_end;    r_approx <= n_approx;
        r_b      <= n_b;      r_first  <= n_first;
        r_w      <= n_w;      r_dm     <= n_dm;     r_dd     <= n_dd;
        r_dr     <= n_dr;     r_status <= n_status; r_hit    <= n_hit;
        r_found  <= n_found;
        r_o_status <= n_o_status; r_o_hit   <= n_o_hit;   r_o_found <= n_o_found;
        r_o_entry  <= n_o_entry;  r_o_seg   <= n_o_seg;   r_o_query <= n_o_query;
        r_o_miss   <= n_o_miss;
    end

    sli_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(k_wdata),
        .i_raddr(k_raddr), .o_rdata(k_rdata)
    );

    sli_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(k_waddr), .i_wdata(v_wdata),
        .i_raddr(k_raddr), .o_rdata(v_rdata)
    );

    sli_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_seg_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    sli_sdiv u_sdiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_dgo), .i_m(r_dm), .i_d(r_dd),
        .i_r(r_dr), .o_done(div_done), .o_quot(div_quot)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_hit           = r_o_hit;
    assign o_found_value   = r_o_found;
    assign o_entry_total   = r_o_entry;
    assign o_segment_total = r_o_seg;
    assign o_query_total   = r_o_query;
    assign o_miss_total    = r_o_miss;

endmodule

// ----- src/sli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/sli_sdiv.sv -----
// Serial scaled divider: floor(m * d / r) for d < r, one half-step per cycle.
module sli_sdiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [sli_pkg::DIV_MW-1:0] i_m,
    input  logic [63:0]               i_d,
    input  logic [63:0]               i_r,
    output logic                      o_done,
    output logic [sli_pkg::DIV_MW-1:0] o_quot
);

    localparam int MW = sli_pkg::DIV_MW;
    localparam int BW = $clog2(MW);

    logic          r_busy, n_busy;
    logic          r_phase, n_phase;
    logic          r_done, n_done;
    logic [BW-1:0] r_bit, n_bit;
    logic [MW-1:0] r_m, n_m;
    logic [MW-1:0] r_q, n_q;
    logic [63:0]   r_d, n_d;
    logic [63:0]   r_r, n_r;
    logic [63:0]   r_rem, n_rem;
    logic          dbl_ge, add_ge, last_bit;

    assign dbl_ge   = r_rem >= (r_r - r_rem);
    assign add_ge   = r_rem >= (r_r - r_d);
    assign last_bit = (r_bit == '0);

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_done  = 1'b0;
        n_bit   = r_bit;
        n_m     = r_m;
        n_q     = r_q;
        n_d     = r_d;
        n_r     = r_r;
        n_rem   = r_rem;
        if (i_go) begin
            n_busy  = 1'b1;
            n_phase = 1'b0;
            n_bit   = BW'(MW - 1);
            n_m     = i_m;
            n_d     = i_d;
            n_r     = i_r;
            n_q     = '0;
            n_rem   = '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                // double the remainder, shift in one quotient bit
                n_q   = {r_q[MW-2:0], dbl_ge};
                n_rem = dbl_ge ? r_rem - (r_r - r_rem) : r_rem + r_rem;
                if (r_m[r_bit]) begin
                    n_phase = 1'b1;
                end else if (last_bit) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end else begin
                // add d for a set multiplier bit
                n_q     = r_q + MW'(add_ge);
                n_rem   = add_ge ? r_rem - (r_r - r_d) : r_rem + r_d;
                n_phase = 1'b0;
                if (last_bit) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_bit <= n_bit;
        r_m   <= n_m;
        r_q   <= n_q;
        r_d   <= n_d;
        r_r   <= n_r;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
